// ===== rtl/core/tfm_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle facet metrics package
// Shared counts and the longest-edge selector type.
// ----------------------------------------------------------------------------
package tfm_pkg;

  localparam int NUM_VERT = 3;
  localparam int NUM_AXIS = 3;

  typedef enum logic [1:0] {
    BASE_A,
    BASE_B,
    BASE_C
  } base_sel_t;

endpackage

// ===== rtl/core/triangle_facet_metrics.sv =====
// ----------------------------------------------------------------------------
// Triangle facet metrics
// Longest edge, edge vectors, area, width and height of one triangle per
// request, in signed fixed point.
// ----------------------------------------------------------------------------
//  Channel  Side    Payload
//  s_*      slave   three vertices x, y, z
//  m_*      master  base, long edge, other edge, area, width, height
//
//  One request per cycle while the output queue is not full; the area root
//  and height divide each resolve one bit per register stage.
//  Reset clears stage valids and the two-entry output queue.
//  A stalled master holds the whole pipeline only once the output queue is
//  full; s_tready comes from the queue count register.
// ----------------------------------------------------------------------------
module triangle_facet_metrics
  import tfm_pkg::*;
#(
  parameter  int COORD_BITS = 24,
  parameter  int FRAC_BITS  = 12,
  localparam int C      = COORD_BITS,
  localparam int E      = C + 1,
  localparam int WSQ_W  = 2 * E,
  localparam int SQ_W   = 4 * E + 2,
  localparam int N      = SQ_W / 2,
  localparam int AREA_W = 2 * C - FRAC_BITS + 1,
  localparam int SIDE_W = 3 * C + 6 * E,
  localparam int IN_W   = NUM_VERT * NUM_AXIS * C,
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W  = SIDE_W + AREA_W + 2 * E,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y, vertex_b_z,
  // vertex_c_x, vertex_c_y, vertex_c_z
  input  logic [IN_TW-1:0]  s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // base_x, base_y, base_z, long_edge_x, long_edge_y, long_edge_z,
  // other_edge_x, other_edge_y, other_edge_z, tri_area, tri_width, tri_height
  output logic [OUT_TW-1:0] m_tdata
);

  logic                ce;
  logic                fr_valid;
  logic [SQ_W-1:0]     fr_sum;
  logic [WSQ_W-1:0]    fr_wsq;
  logic [SIDE_W-1:0]   fr_side;
  logic                sq_valid;
  logic [N-1:0]        sq_root;
  logic [E-1:0]        sq_wroot;
  logic [SIDE_W-1:0]   sq_side;
  logic                dv_valid;
  logic [E-1:0]        dv_height;
  logic [E-1:0]        dv_width;
  logic [N+SIDE_W-1:0] dv_side;
  logic [OUT_W-1:0]    result;

  logic [OUT_W-1:0]    queue [2];
  logic                wr_ptr, rd_ptr;
  logic [1:0]          cnt;
  logic                push, pop;
  logic [OUT_W-1:0]    head;

  assign ce       = (cnt != 2'd2);
  assign s_tready = ce;

  tfm_front #(.C(C)) u_front (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata[IN_W-1:0]),
    .out_valid (fr_valid),
    .out_sum   (fr_sum),
    .out_wsq   (fr_wsq),
    .out_side  (fr_side)
  );

  tfm_sqrt #(.SQ_W(SQ_W), .WSQ_W(WSQ_W), .SIDE_W(SIDE_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (fr_valid),
    .in_sum    (fr_sum),
    .in_wsq    (fr_wsq),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_wroot (sq_wroot),
    .out_side  (sq_side)
  );

  tfm_div #(.E(E), .F(FRAC_BITS), .N(N), .SIDE_W(N + SIDE_W)) u_div (
    .clk        (clk),
    .rst        (rst),
    .ce         (ce),
    .in_valid   (sq_valid),
    .in_root    (sq_root),
    .in_width   (sq_wroot),
    .in_side    ({sq_root, sq_side}),
    .out_valid  (dv_valid),
    .out_height (dv_height),
    .out_width  (dv_width),
    .out_side   (dv_side)
  );

  assign result = {dv_height, dv_width,
                   AREA_W'(dv_side[N+SIDE_W-1:SIDE_W] >> (FRAC_BITS + 1)),
                   dv_side[SIDE_W-1:0]};

  assign push = ce & dv_valid;
  assign pop  = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= result;
    end
  end

  assign head     = queue[rd_ptr];
  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = OUT_TW'(head);

  logic [E-1:0]      chk_lx, chk_lx_abs, chk_width, chk_height;
  logic [AREA_W-1:0] chk_area;

  assign chk_lx     = head[3 * C +: E];
  assign chk_lx_abs = chk_lx[E-1] ? -chk_lx : chk_lx;
  assign chk_area   = head[SIDE_W +: AREA_W];
  assign chk_width  = head[SIDE_W + AREA_W +: E];
  assign chk_height = head[SIDE_W + AREA_W + E +: E];

  a_zero_width: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && chk_width == '0 |-> chk_height == '0 && chk_area == '0)
    else $error("zero width with nonzero area or height");

  a_width_covers_edge: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> chk_width >= chk_lx_abs)
    else $error("width shorter than long edge component");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 && !m_tready |=> !s_tready)
    else $error("request taken with output queue full");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 |-> !push)
    else $error("result pushed into full output queue");

endmodule

// ===== rtl/core/tfm_front.sv =====
// ----------------------------------------------------------------------------
// Triangle facet metrics front end
// Edge differences, squared edge lengths, longest edge pick, cross product
// and the sum of its squared components, over ten register stages.
// ----------------------------------------------------------------------------
module tfm_front
  import tfm_pkg::*;
#(
  parameter  int C      = 24,
  localparam int E      = C + 1,
  localparam int P      = 2 * E,
  localparam int H      = E,
  localparam int SQ_W   = 4 * E + 2,
  localparam int SIDE_W = 3 * C + 6 * E
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ce,
  input  logic                         in_valid,
  input  logic [NUM_VERT*NUM_AXIS*C-1:0] in_data,
  output logic                         out_valid,
  output logic [SQ_W-1:0]              out_sum,
  output logic [P-1:0]                 out_wsq,
  output logic [SIDE_W-1:0]            out_side
);

  logic signed [C-1:0] va [NUM_AXIS];
  logic signed [C-1:0] vb [NUM_AXIS];
  logic signed [C-1:0] vc [NUM_AXIS];

  logic                v1, v2, v3, v4, v5, v6, v7, v8, v9, v10;
  logic signed [C-1:0] a1 [NUM_AXIS], b1 [NUM_AXIS], c1 [NUM_AXIS];
  logic signed [C-1:0] a2 [NUM_AXIS], b2 [NUM_AXIS], c2 [NUM_AXIS];
  logic signed [C-1:0] a3 [NUM_AXIS], b3 [NUM_AXIS], c3 [NUM_AXIS];
  logic signed [E-1:0] dab1 [NUM_AXIS], dbc1 [NUM_AXIS], dca1 [NUM_AXIS];
  logic signed [E-1:0] nab1 [NUM_AXIS], nbc1 [NUM_AXIS], nca1 [NUM_AXIS];
  logic signed [E-1:0] dab2 [NUM_AXIS], dbc2 [NUM_AXIS], dca2 [NUM_AXIS];
  logic signed [E-1:0] nab2 [NUM_AXIS], nbc2 [NUM_AXIS], nca2 [NUM_AXIS];
  logic signed [E-1:0] dab3 [NUM_AXIS], dbc3 [NUM_AXIS], dca3 [NUM_AXIS];
  logic signed [E-1:0] nab3 [NUM_AXIS], nbc3 [NUM_AXIS], nca3 [NUM_AXIS];
  logic [P-1:0]        sab2 [NUM_AXIS], sbc2 [NUM_AXIS], sca2 [NUM_AXIS];
  logic [P-1:0]        d12_3, d23_3, d31_3;

  base_sel_t           sel;
  logic signed [C-1:0] base_next [NUM_AXIS];
  logic signed [E-1:0] e1_next [NUM_AXIS];
  logic signed [E-1:0] e2_next [NUM_AXIS];
  logic [P-1:0]        wsq_next;

  logic signed [E-1:0] e1_4 [NUM_AXIS], e2_4 [NUM_AXIS];
  logic [SIDE_W-1:0]   side4, side5, side6, side7, side8, side9, side10;
  logic [P-1:0]        wsq4, wsq5, wsq6, wsq7, wsq8, wsq9, wsq10;
  logic signed [P-1:0] prod5 [2*NUM_AXIS];
  logic signed [P:0]   cr6 [NUM_AXIS];
  logic [P-1:0]        mag7 [NUM_AXIS];
  logic [2*H-1:0]      hh8 [NUM_AXIS], hl8 [NUM_AXIS], ll8 [NUM_AXIS];
  logic [2*P-1:0]      sq9 [NUM_AXIS];
  logic [SQ_W-1:0]     sum10;

  always_comb begin
    for (int k = 0; k < NUM_AXIS; k++) begin
      va[k] = in_data[(0 * NUM_AXIS + k) * C +: C];
      vb[k] = in_data[(1 * NUM_AXIS + k) * C +: C];
      vc[k] = in_data[(2 * NUM_AXIS + k) * C +: C];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0;
    end else if (ce) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      v6 <= v5; v7 <= v6; v8 <= v7; v9 <= v8; v10 <= v9;
    end
  end

  // differences, squares and squared lengths
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < NUM_AXIS; k++) begin
        a1[k]   <= va[k];
        b1[k]   <= vb[k];
        c1[k]   <= vc[k];
        dab1[k] <= E'(vb[k]) - E'(va[k]);
        dbc1[k] <= E'(vc[k]) - E'(vb[k]);
        dca1[k] <= E'(va[k]) - E'(vc[k]);
        nab1[k] <= E'(va[k]) - E'(vb[k]);
        nbc1[k] <= E'(vb[k]) - E'(vc[k]);
        nca1[k] <= E'(vc[k]) - E'(va[k]);

        a2[k] <= a1[k]; b2[k] <= b1[k]; c2[k] <= c1[k];
        dab2[k] <= dab1[k]; dbc2[k] <= dbc1[k]; dca2[k] <= dca1[k];
        nab2[k] <= nab1[k]; nbc2[k] <= nbc1[k]; nca2[k] <= nca1[k];
        sab2[k] <= P'(dab1[k] * dab1[k]);
        sbc2[k] <= P'(dbc1[k] * dbc1[k]);
        sca2[k] <= P'(dca1[k] * dca1[k]);

        a3[k] <= a2[k]; b3[k] <= b2[k]; c3[k] <= c2[k];
        dab3[k] <= dab2[k]; dbc3[k] <= dbc2[k]; dca3[k] <= dca2[k];
        nab3[k] <= nab2[k]; nbc3[k] <= nbc2[k]; nca3[k] <= nca2[k];
      end
      d12_3 <= sab2[0] + sab2[1] + sab2[2];
      d23_3 <= sbc2[0] + sbc2[1] + sbc2[2];
      d31_3 <= sca2[0] + sca2[1] + sca2[2];
    end
  end

  // longest edge, ties resolved a-b then b-c then c-a
  always_comb begin
    if (d12_3 >= d23_3 && d12_3 >= d31_3) begin
      sel = BASE_A;
    end else if (d23_3 >= d31_3) begin
      sel = BASE_B;
    end else begin
      sel = BASE_C;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_AXIS; k++) begin
      case (sel)
        BASE_A: begin
          base_next[k] = a3[k];
          e1_next[k]   = dab3[k];
          e2_next[k]   = nca3[k];
        end
        BASE_B: begin
          base_next[k] = b3[k];
          e1_next[k]   = dbc3[k];
          e2_next[k]   = nab3[k];
        end
        default: begin
          base_next[k] = c3[k];
          e1_next[k]   = dca3[k];
          e2_next[k]   = nbc3[k];
        end
      endcase
    end
    case (sel)
      BASE_A:  wsq_next = d12_3;
      BASE_B:  wsq_next = d23_3;
      default: wsq_next = d31_3;
    endcase
  end

  // cross product and sum of squared components
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < NUM_AXIS; k++) begin
        e1_4[k] <= e1_next[k];
        e2_4[k] <= e2_next[k];
        side4[k * C +: C]                         <= base_next[k];
        side4[NUM_AXIS * C + k * E +: E]          <= e1_next[k];
        side4[NUM_AXIS * (C + E) + k * E +: E]    <= e2_next[k];
      end
      wsq4 <= wsq_next;

      prod5[0] <= P'(e1_4[1] * e2_4[2]);
      prod5[1] <= P'(e1_4[2] * e2_4[1]);
      prod5[2] <= P'(e1_4[2] * e2_4[0]);
      prod5[3] <= P'(e1_4[0] * e2_4[2]);
      prod5[4] <= P'(e1_4[0] * e2_4[1]);
      prod5[5] <= P'(e1_4[1] * e2_4[0]);

      for (int k = 0; k < NUM_AXIS; k++) begin
        cr6[k]  <= (P + 1)'(prod5[2 * k]) - (P + 1)'(prod5[2 * k + 1]);
        mag7[k] <= cr6[k][P] ? P'(-cr6[k]) : P'(cr6[k]);
        hh8[k]  <= mag7[k][P-1:H] * mag7[k][P-1:H];
        hl8[k]  <= mag7[k][P-1:H] * mag7[k][H-1:0];
        ll8[k]  <= mag7[k][H-1:0] * mag7[k][H-1:0];
        sq9[k]  <= {hh8[k], ll8[k]} + ((2 * P)'(hl8[k]) << (H + 1));
      end
      sum10 <= SQ_W'(sq9[0]) + SQ_W'(sq9[1]) + SQ_W'(sq9[2]);

      side5 <= side4; side6 <= side5; side7 <= side6;
      side8 <= side7; side9 <= side8; side10 <= side9;
      wsq5 <= wsq4; wsq6 <= wsq5; wsq7 <= wsq6;
      wsq8 <= wsq7; wsq9 <= wsq8; wsq10 <= wsq9;
    end
  end

  assign out_valid = v10;
  assign out_sum   = sum10;
  assign out_wsq   = wsq10;
  assign out_side  = side10;

endmodule

// ===== rtl/core/tfm_sqrt.sv =====
// ----------------------------------------------------------------------------
// Triangle facet metrics root pipeline
// Two digit-by-digit square roots, one root bit per register stage; the
// narrow root runs in the last stages of the wide one.
// ----------------------------------------------------------------------------
module tfm_sqrt #(
  parameter  int SQ_W   = 102,
  parameter  int WSQ_W  = 50,
  parameter  int SIDE_W = 222,
  localparam int N      = SQ_W / 2,
  localparam int WN     = WSQ_W / 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   in_sum,
  input  logic [WSQ_W-1:0]  in_wsq,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [N-1:0]      out_root,
  output logic [WN-1:0]     out_wroot,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld   [0:N];
  logic [SQ_W-1:0]   rad   [0:N];
  logic [N+1:0]      rem   [0:N];
  logic [N-1:0]      root  [0:N];
  logic [WSQ_W-1:0]  wrad  [0:N];
  logic [WN+1:0]     wrem  [0:N];
  logic [WN-1:0]     wroot [0:N];
  logic [SIDE_W-1:0] side  [0:N];

  assign vld[0]   = in_valid;
  assign rad[0]   = in_sum;
  assign rem[0]   = '0;
  assign root[0]  = '0;
  assign wrad[0]  = in_wsq;
  assign wrem[0]  = '0;
  assign wroot[0] = '0;
  assign side[0]  = in_side;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [N+1:0] remx, trial;

    assign remx  = {rem[i][N-1:0], rad[i][SQ_W-1:SQ_W-2]};
    assign trial = {root[i], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (ce) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rad[i+1]  <= rad[i] << 2;
        side[i+1] <= side[i];
        if (remx >= trial) begin
          rem[i+1]  <= remx - trial;
          root[i+1] <= {root[i][N-2:0], 1'b1};
        end else begin
          rem[i+1]  <= remx;
          root[i+1] <= {root[i][N-2:0], 1'b0};
        end
      end
    end

    if (i >= N - WN) begin : g_wide
      logic [WN+1:0] wremx, wtrial;

      assign wremx  = {wrem[i][WN-1:0], wrad[i][WSQ_W-1:WSQ_W-2]};
      assign wtrial = {wroot[i], 2'b01};

      always_ff @(posedge clk) begin
        if (ce) begin
          wrad[i+1] <= wrad[i] << 2;
          if (wremx >= wtrial) begin
            wrem[i+1]  <= wremx - wtrial;
            wroot[i+1] <= {wroot[i][WN-2:0], 1'b1};
          end else begin
            wrem[i+1]  <= wremx;
            wroot[i+1] <= {wroot[i][WN-2:0], 1'b0};
          end
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (ce) begin
          wrad[i+1]  <= wrad[i];
          wrem[i+1]  <= wrem[i];
          wroot[i+1] <= wroot[i];
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign out_root  = root[N];
  assign out_wroot = wroot[N];
  assign out_side  = side[N];

endmodule

// ===== rtl/core/tfm_div.sv =====
// ----------------------------------------------------------------------------
// Triangle facet metrics height divider
// Overflow and zero-width check, then a restoring divide with one quotient
// bit per register stage.
// ----------------------------------------------------------------------------
module tfm_div #(
  parameter int E      = 25,
  parameter int F      = 12,
  parameter int N      = 51,
  parameter int SIDE_W = 222
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_valid,
  input  logic [N-1:0]      in_root,
  input  logic [E-1:0]      in_width,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [E-1:0]      out_height,
  output logic [E-1:0]      out_width,
  output logic [SIDE_W-1:0] out_side
);

  localparam logic [N+F+1:0] LOW_ONE = (N + F + 2)'(1) << (F + 1);
  localparam logic [N-1:0]   LOW_MASK = N'(LOW_ONE - 1'b1);

  logic [N-1:0]      dividend;

  logic              vld   [0:E];
  logic [N-1:0]      r     [0:E];
  logic [E-1:0]      q     [0:E];
  logic [E-1:0]      w     [0:E];
  logic              sat   [0:E];
  logic              zero  [0:E];
  logic [SIDE_W-1:0] side  [0:E];

  assign dividend = in_root & ~LOW_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      r[0]    <= dividend;
      q[0]    <= '0;
      w[0]    <= in_width;
      zero[0] <= (in_width == '0);
      sat[0]  <= (in_width != '0) && (dividend >= N'({in_width, E'(0)}));
      side[0] <= in_side;
    end
  end

  for (genvar j = 0; j < E; j++) begin : g_bit
    logic [N-1:0] sub;

    assign sub = N'(w[j]) << (E - 1 - j);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (ce) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        w[j+1]    <= w[j];
        sat[j+1]  <= sat[j];
        zero[j+1] <= zero[j];
        side[j+1] <= side[j];
        if (r[j] >= sub) begin
          r[j+1] <= r[j] - sub;
          q[j+1] <= {q[j][E-2:0], 1'b1};
        end else begin
          r[j+1] <= r[j];
          q[j+1] <= {q[j][E-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid  = vld[E];
  assign out_height = zero[E] ? '0 : (sat[E] ? '1 : q[E]);
  assign out_width  = w[E];
  assign out_side   = side[E];

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle facet metrics testbench
// Drives triangles through a directed table and then random requests, with
// random gaps on both sides and one long output hold-off, and checks every
// result against a predictor of longest edge, edge vectors, area, width and
// height, or against table values for some directed rows.
// ----------------------------------------------------------------------------
module testbench;
  import tfm_pkg::*;

  localparam int C      = 24;
  localparam int F      = 12;
  localparam int E      = C + 1;
  localparam int AREA_W = 2 * C - F + 1;
  localparam int IN_TW  = 216;
  localparam int OUT_TW = 312;
  localparam int N_DIR  = 16;
  localparam int N_RAND = 1200;
  localparam int LATENCY = 3 * C + 16;
  localparam longint LIMIT = 400000;

  typedef logic signed [C-1:0] coord_t;

  typedef struct packed {
    logic [E-1:0]      height;
    logic [E-1:0]      width;
    logic [AREA_W-1:0] area;
    logic [E-1:0]      oz, oy, ox;
    logic [E-1:0]      lz, ly, lx;
    logic [C-1:0]      bz, by, bx;
  } facet_t;

  logic              clk = 0;
  logic              rst = 1;
  logic              s_tvalid = 0;
  logic              s_tready;
  logic [IN_TW-1:0]  s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 0;
  logic [OUT_TW-1:0] m_tdata;

  facet_t facets_due[$];
  int     errors = 0;
  longint cycles = 0;
  bit     sending_done = 0;
  bit     hold_off = 0;

  coord_t dir_vtx[N_DIR][9];
  bit     dir_known[N_DIR];
  logic [AREA_W-1:0] dir_area[N_DIR];
  logic [E-1:0]      dir_width[N_DIR];
  logic [E-1:0]      dir_height[N_DIR];

  triangle_facet_metrics dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned root_floor(logic [127:0] s);
    logic [63:0]  r;
    logic [63:0]  cand;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= s) r = cand;
    end
    return r;
  endfunction

  function automatic facet_t facet_of(coord_t v[9]);
    facet_t f;
    longint p[3][3];
    longint d12, d23, d31, wsq;
    longint e1[3], e2[3], cr[3];
    logic [127:0] s;
    longint unsigned w, a, h;
    int bs, nx, rm;
    for (int i = 0; i < 9; i++) p[i / 3][i % 3] = longint'(v[i]);
    d12 = 0; d23 = 0; d31 = 0;
    for (int i = 0; i < 3; i++) begin
      d12 += (p[1][i] - p[0][i]) * (p[1][i] - p[0][i]);
      d23 += (p[2][i] - p[1][i]) * (p[2][i] - p[1][i]);
      d31 += (p[0][i] - p[2][i]) * (p[0][i] - p[2][i]);
    end
    if (d12 >= d23 && d12 >= d31) begin
      bs = BASE_A; nx = 1; rm = 2; wsq = d12;
    end else if (d23 >= d31) begin
      bs = BASE_B; nx = 2; rm = 0; wsq = d23;
    end else begin
      bs = BASE_C; nx = 0; rm = 1; wsq = d31;
    end
    for (int i = 0; i < 3; i++) begin
      e1[i] = p[nx][i] - p[bs][i];
      e2[i] = p[rm][i] - p[bs][i];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    s = 0;
    for (int i = 0; i < 3; i++) begin
      if (cr[i] < 0) cr[i] = -cr[i];
      s += {64'd0, cr[i]} * {64'd0, cr[i]};
    end
    a = root_floor(s) >> (F + 1);
    w = root_floor({64'd0, wsq});
    if (w == 0) h = 0;
    else begin
      h = ((a << 1) << F) / w;
      if (h > {E{1'b1}}) h = {E{1'b1}};
    end
    f.bx = C'(p[bs][0]); f.by = C'(p[bs][1]); f.bz = C'(p[bs][2]);
    f.lx = E'(e1[0]); f.ly = E'(e1[1]); f.lz = E'(e1[2]);
    f.ox = E'(e2[0]); f.oy = E'(e2[1]); f.oz = E'(e2[2]);
    f.area = AREA_W'(a); f.width = E'(w); f.height = E'(h);
    return f;
  endfunction

  task automatic send_triangle(coord_t v[9], facet_t want);
    int gap;
    logic [IN_TW-1:0] word;
    gap = $urandom_range(0, 5);
    word = '0;
    for (int i = 0; i < 9; i++) word[i*C +: C] = v[i];
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= word;
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    facets_due = {facets_due, want};
    @(negedge clk);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 8191) - 4096);
      2: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      default: return coord_t'($urandom_range(0, 3) - 2);
    endcase
  endfunction

  task automatic load_directed();
    coord_t z[9];
    coord_t mx = 24'h7fffff;
    coord_t mn = 24'h800000;
    for (int i = 0; i < 9; i++) z[i] = 0;
    for (int r = 0; r < N_DIR; r++) begin
      dir_vtx[r] = z;
      dir_known[r] = 0;
    end
    dir_known[0] = 1; dir_area[0] = 0; dir_width[0] = 0; dir_height[0] = 0;
    dir_vtx[1] = '{mx, mx, mx, mx, mx, mx, mx, mx, mx};
    dir_known[1] = 1; dir_area[1] = 0; dir_width[1] = 0; dir_height[1] = 0;
    dir_vtx[2] = '{mn, mn, mn, mn, mn, mn, mn, mn, mn};
    dir_known[2] = 1; dir_area[2] = 0; dir_width[2] = 0; dir_height[2] = 0;
    dir_vtx[3] = '{0, 0, 0, 4096, 0, 0, 8192, 0, 0};
    dir_known[3] = 1; dir_area[3] = 0; dir_width[3] = 8192; dir_height[3] = 0;
    dir_vtx[4] = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};
    dir_vtx[5] = '{0, 0, 0, 0, 4096, 0, 4096, 0, 0};
    dir_vtx[6] = '{4096, 0, 0, 0, 0, 0, 0, 4096, 0};
    dir_vtx[7] = '{0, 0, 0, 4096, 0, 0, 2048, 3547, 0};
    dir_vtx[8] = '{mn, mn, mn, mx, mx, mx, mn, mx, mn};
    dir_vtx[9] = '{mx, mn, mx, mn, mx, mn, mx, mx, mn};
    dir_vtx[10] = '{mn, mn, mn, mx, mn, mn, mn, mx, mn};
    dir_vtx[11] = '{mn, 0, mx, mx, mn, 0, 0, mx, mn};
    dir_vtx[12] = '{-1, -1, -1, 1, 1, 1, 1, -1, 0};
    dir_vtx[13] = '{mn, mn, 0, mx, mn, 0, mn, mx, 0};
    dir_vtx[14] = '{24'h555555, 24'haaaaaa, 24'h0f0f0f, 24'hf0f0f0, 24'h333333,
                    24'hcccccc, 24'h123456, 24'hedcba9, 24'h7fffff};
    dir_vtx[15] = '{0, 0, 0, 0, 0, 4096, 0, 4096, 0};
  endtask

  initial begin
    coord_t v[9];
    int mode;
    facet_t f;
    load_directed();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    for (int r = 0; r < N_DIR; r++) begin
      f = facet_of(dir_vtx[r]);
      if (dir_known[r]) begin
        f.area = dir_area[r];
        f.width = dir_width[r];
        f.height = dir_height[r];
      end
      send_triangle(dir_vtx[r], f);
    end
    for (int n = 0; n < N_RAND; n++) begin
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++)
        v[i] = rand_coord(mode < 5 ? 0 : mode < 8 ? 1 : mode < 9 ? 2 : 3);
      if ($urandom_range(0, 9) == 0) begin
        v[6] = coord_t'(v[0] + (v[3] - v[0]) * 2);
        v[7] = coord_t'(v[1] + (v[4] - v[1]) * 2);
        v[8] = coord_t'(v[2] + (v[5] - v[2]) * 2);
      end
      send_triangle(v, facet_of(v));
    end
    s_tvalid <= 0;
    sending_done = 1;
  end

  initial begin
    #2000;
    @(negedge clk);
    hold_off = 1;
    repeat (300) @(negedge clk);
    hold_off = 0;
  end

  initial begin
    int gap;
    facet_t got, want;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0 || hold_off || rst) begin
        m_tready <= 0;
        repeat (gap) @(negedge clk);
        while (hold_off || rst) @(negedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got = m_tdata[$bits(facet_t)-1:0];
      if (facets_due.size() == 0) begin
        $display("%0t unexpected result %h", $time, got);
        errors++;
      end else begin
        want = facets_due.pop_front();
        if (got !== want) begin
          $display("%0t base exp %h %h %h got %h %h %h", $time,
                   want.bx, want.by, want.bz, got.bx, got.by, got.bz);
          $display("%0t long exp %h %h %h got %h %h %h", $time,
                   want.lx, want.ly, want.lz, got.lx, got.ly, got.lz);
          $display("%0t other exp %h %h %h got %h %h %h", $time,
                   want.ox, want.oy, want.oz, got.ox, got.oy, got.oz);
          $display("%0t area/width/height exp %0d %0d %0d got %0d %0d %0d",
                   $time, want.area, want.width, want.height,
                   got.area, got.width, got.height);
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("triangle_facet_metrics: mismatch");
        $finish;
      end
      if (sending_done && facets_due.size() == 0) begin
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0) $display("triangle_facet_metrics: match");
        else $display("triangle_facet_metrics: mismatch");
        $finish;
      end
    end
  end
endmodule

// ===== triangle_facet_metrics.f =====
rtl/core/tfm_pkg.sv
rtl/core/tfm_front.sv
rtl/core/tfm_sqrt.sv
rtl/core/tfm_div.sv
rtl/core/triangle_facet_metrics.sv
tb/sv/testbench.sv
